@@ src/ssm_pkg.sv @@
package ssm_pkg;

  localparam int unsigned MAX_PARENTS_DEF  = 32;
  localparam int unsigned MAX_CHILDREN_DEF = 32;

  localparam logic CMD_PARENT = 1'b0;
  localparam logic CMD_CHILD  = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] fitness_key;
    logic        [7:0]  entry_tag;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] survivor_key;
    logic        [7:0]  survivor_tag;
    logic               from_child;
    logic               last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_MRG_RD,
    ST_MRG_SEL,
    ST_MRG_OUT
  } ssm_state_e;

endpackage

@@ src/sorted_survivor_merge.sv @@
// Parent item: written straight to the parent store. Child item: inserted into the sorted
// child store, each insertion step being a read, then a compare.
// Run: after the last item, a store read state, then a select and an output state per survivor;
// the output state holds while the output is stalled. Store reads are registered.
// Reset clears the counts, the sequencer and the output valid; stores are not cleared.
module sorted_survivor_merge #(
  parameter int unsigned MAX_PARENTS  = ssm_pkg::MAX_PARENTS_DEF,
  parameter int unsigned MAX_CHILDREN = ssm_pkg::MAX_CHILDREN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssm_pkg::out_item_t out_item_o
);
  import ssm_pkg::*;

  localparam int unsigned PIDX_W = (MAX_PARENTS > 1) ? $clog2(MAX_PARENTS) : 1;
  localparam int unsigned CIDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int unsigned PCNT_W = $clog2(MAX_PARENTS + 1);
  localparam int unsigned CCNT_W = $clog2(MAX_CHILDREN + 1);

  ssm_state_e state_q, state_d;
  logic [PCNT_W-1:0] pc_q, pc_d, ip_q, ip_d, sel_q, sel_d;
  logic [CCNT_W-1:0] cc_q, cc_d, ic_q, ic_d;
  logic [CIDX_W-1:0] j_q, j_d;
  logic signed [31:0] key_q, key_d;
  logic [7:0]         tag_q, tag_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic signed [31:0] p_key_mem [MAX_PARENTS];
  logic [7:0]         p_tag_mem [MAX_PARENTS];
  logic signed [31:0] c_key_mem [MAX_CHILDREN];
  logic [7:0]         c_tag_mem [MAX_CHILDREN];
  logic signed [31:0] p_rd_key_q, c_rd_key_q;
  logic [7:0]         p_rd_tag_q, c_rd_tag_q;

  logic               p_we;
  logic [PIDX_W-1:0]  p_waddr, p_raddr;
  logic               c_we;
  logic [CIDX_W-1:0]  c_waddr, c_raddr;
  logic signed [31:0] c_wkey;
  logic [7:0]         c_wtag;
  logic               ins_done;
  logic               take_child;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign p_waddr     = pc_q[PIDX_W-1:0];
  assign p_raddr     = ip_q[PIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_key_mem[p_waddr] <= in_item_i.fitness_key;
      p_tag_mem[p_waddr] <= in_item_i.entry_tag;
    end
    p_rd_key_q <= p_key_mem[p_raddr];
    p_rd_tag_q <= p_tag_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_key_mem[c_waddr] <= c_wkey;
      c_tag_mem[c_waddr] <= c_wtag;
    end
    c_rd_key_q <= c_key_mem[c_raddr];
    c_rd_tag_q <= c_tag_mem[c_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cc_q        <= '0;
      ip_q        <= '0;
      ic_q        <= '0;
      sel_q       <= '0;
      j_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cc_q        <= cc_d;
      ip_q        <= ip_d;
      ic_q        <= ic_d;
      sel_q       <= sel_d;
      j_q         <= j_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
    out_q <= out_d;
  end

  assign take_child = (ic_q < cc_q) && !(p_rd_key_q < c_rd_key_q);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cc_d        = cc_q;
    ip_d        = ip_q;
    ic_d        = ic_q;
    sel_d       = sel_q;
    j_d         = j_q;
    key_d       = key_q;
    tag_d       = tag_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    p_we        = 1'b0;
    c_we        = 1'b0;
    c_waddr     = j_q;
    c_wkey      = key_q;
    c_wtag      = tag_q;
    c_raddr     = ic_q[CIDX_W-1:0];
    ins_done    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d  = in_item_i.fitness_key;
          tag_d  = in_item_i.entry_tag;
          last_d = in_item_i.last_item;
          if (in_item_i.command == CMD_CHILD) begin
            if (cc_q < CCNT_W'(MAX_CHILDREN)) begin
              j_d     = cc_q[CIDX_W-1:0];
              state_d = ST_INS_RD;
            end else if (in_item_i.last_item) begin
              // store full: drop the entry but still run if any parents are loaded
              if (pc_q == '0) begin
                cc_d = '0;
              end else begin
                state_d = ST_MRG_RD;
              end
            end
          end else begin
            if (pc_q < PCNT_W'(MAX_PARENTS)) begin
              p_we = 1'b1;
              pc_d = pc_q + PCNT_W'(1);
            end
            if (in_item_i.last_item) begin
              if (pc_d == '0) begin
                cc_d = '0;
              end else begin
                state_d = ST_MRG_RD;
              end
            end
          end
          ip_d  = '0;
          ic_d  = '0;
          sel_d = '0;
        end
      end
      ST_INS_RD: begin
        if (j_q == '0) begin
          c_we     = 1'b1;
          ins_done = 1'b1;
        end else begin
          c_raddr = j_q - CIDX_W'(1);
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        c_we = 1'b1;
        if (c_rd_key_q > key_q) begin
          // shift the larger entry up one place
          c_wkey  = c_rd_key_q;
          c_wtag  = c_rd_tag_q;
          j_d     = j_q - CIDX_W'(1);
          state_d = ST_INS_RD;
        end else begin
          ins_done = 1'b1;
        end
      end
      ST_MRG_RD: begin
        state_d = ST_MRG_SEL;
      end
      ST_MRG_SEL: begin
        if (take_child) begin
          out_d.survivor_key = c_rd_key_q;
          out_d.survivor_tag = c_rd_tag_q;
          out_d.from_child   = 1'b1;
          ic_d               = ic_q + CCNT_W'(1);
        end else begin
          out_d.survivor_key = p_rd_key_q;
          out_d.survivor_tag = p_rd_tag_q;
          out_d.from_child   = 1'b0;
          ip_d               = ip_q + PCNT_W'(1);
        end
        out_d.last_result = ((sel_q + PCNT_W'(1)) == pc_q);
        sel_d             = sel_q + PCNT_W'(1);
        out_valid_d       = 1'b1;
        state_d           = ST_MRG_OUT;
      end
      ST_MRG_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (sel_q == pc_q) begin
            pc_d    = '0;
            cc_d    = '0;
            ip_d    = '0;
            ic_d    = '0;
            sel_d   = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MRG_SEL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ins_done) begin
      cc_d    = cc_q + CCNT_W'(1);
      state_d = ST_IDLE;
      if (last_q) begin
        if (pc_q == '0) begin
          cc_d = '0;
        end else begin
          state_d = ST_MRG_RD;
        end
      end
    end
  end

  a_out_needs_parents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pc_q != '0))
    else $error("survivor offered with no parents loaded");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last_result)
      |=> (state_q == ST_IDLE && pc_q == '0 && cc_q == '0 && !out_valid_o))
    else $error("run did not end after final survivor transfer");

  a_ptrs_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ip_q <= pc_q) && (ic_q <= cc_q) && (sel_q <= pc_q))
    else $error("merge pointer beyond loaded count");

  a_sel_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MRG_OUT) |-> (sel_q == ip_q + PCNT_W'(ic_q)))
    else $error("survivor count out of step with merge pointers");

  a_ins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_RD || state_q == ST_INS_CMP)
      |-> (CCNT_W'(j_q) <= cc_q && cc_q < CCNT_W'(MAX_CHILDREN)))
    else $error("insertion position beyond child count");

endmodule
